// ----- design/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int unsigned CSR_BITS = 5;
   localparam logic [CSR_BITS-1:0] WINDOW_LEN_RESET = 5'd10;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic step;     // an item is taken in this cycle
      logic trim;     // no item; drop the front entry and move the list up
      logic restart;  // clear the list before this item enters
      logic shift;    // front entry leaves the window this step
   } cell_ctl_type;

endpackage

// ----- design/sliding_window_maximum_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit
// Streaming maximum over the last window_len samples (clamped to 1 to
// WINDOW_MAX), kept as a monotonic candidate list in a row of cells.
// ----------------------------------------------------------------------------
//  channel   ports                              direction  notes
//  req       req_valid/req_stall, sample/restart in        one sample per item
//  rsp       rsp_valid/rsp_stall, window_max    out        zero or one per item
//  csr       csr_wr_en/csr_wr_data              in         window_len, no read
//
//  One item per cycle; every cell compares and shifts in the same cycle, and
//  the result is registered, so it shows up the cycle after its item is taken.
//  After window_len is lowered, aged-out front entries past the first are
//  dropped one per cycle with req_stall high; the last goes with the next item.
//  Reset empties the list and the fill count and sets window_len to 10.
//  A result held by rsp_stall blocks new items until it is taken.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit #(
   parameter int unsigned WINDOW_MAX  = 16,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   input  logic                          csr_wr_en,
   input  logic [swm_pkg::CSR_BITS-1:0]  csr_wr_data
);
   import swm_pkg::*;

   localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);

   logic [CSR_BITS-1:0]           window_len_ff, window_len_in;
   logic [LEN_W-1:0]              fill_ff, fill_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;

   logic [LEN_W-1:0]              eff_len;
   logic [LEN_W:0]                age0_inc, age1_inc;
   logic                          trim_need;
   logic                          accept;
   logic [LEN_W-1:0]              fill_base;
   cell_ctl_type                  ctl;

   logic                          c_valid [WINDOW_MAX+1];
   logic signed [SAMPLE_BITS-1:0] c_value [WINDOW_MAX+1];
   logic [LEN_W-1:0]              c_age   [WINDOW_MAX+1];
   logic                          c_keep  [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] c_next  [WINDOW_MAX];

   // empty slot past the last cell
   assign c_valid[WINDOW_MAX] = 1'b0;
   assign c_value[WINDOW_MAX] = '0;
   assign c_age[WINDOW_MAX]   = '0;

   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(window_len_ff) > 32'(WINDOW_MAX)) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = LEN_W'(window_len_ff);
      end

      age0_inc = {1'b0, c_age[0]} + {{LEN_W{1'b0}}, 1'b1};
      age1_inc = {1'b0, c_age[1]} + {{LEN_W{1'b0}}, 1'b1};

      // more than one entry would leave the window: drop front ones first
      trim_need = c_valid[0] & c_valid[1] & (age1_inc >= {1'b0, eff_len});
      req_stall = trim_need | (rsp_valid_ff & rsp_stall);
      accept    = req_valid & ~req_stall;

      ctl.step    = accept;
      ctl.trim    = trim_need;
      ctl.restart = req_restart;
      ctl.shift   = accept & ~req_restart & c_valid[0] &
                    (age0_inc >= {1'b0, eff_len});

      fill_base = req_restart ? '0 : fill_ff;
      fill_in   = fill_ff;
      if (accept) begin
         fill_in = (fill_base >= eff_len) ? eff_len : fill_base + LEN_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      if (accept) begin
         rsp_valid_in = (fill_in == eff_len);
         rsp_max_in   = c_next[0];
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      window_len_in = csr_wr_en ? csr_wr_data : window_len_ff;
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .LEN_W       (LEN_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .sample      (req_sample),
         .eff_len     (eff_len),
         .right_valid (c_valid[i+1]),
         .right_value (c_value[i+1]),
         .right_age   (c_age[i+1]),
         .first_cell  (i == 0),
         .left_keep   ((i == 0) ? 1'b0 : c_keep[(i == 0) ? 0 : i-1]),
         .valid       (c_valid[i]),
         .value       (c_value[i]),
         .age         (c_age[i]),
         .keep        (c_keep[i]),
         .next_value  (c_next[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_len_ff <= window_len_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

endmodule

// ----- design/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the candidate list: value, age and valid, with neighbor handoff.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned LEN_W       = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::cell_ctl_type         ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [LEN_W-1:0]              eff_len,
   input  logic                          right_valid,
   input  logic signed [SAMPLE_BITS-1:0] right_value,
   input  logic [LEN_W-1:0]              right_age,
   input  logic                          first_cell,
   input  logic                          left_keep,
   output logic                          valid,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [LEN_W-1:0]              age,
   output logic                          keep,
   output logic signed [SAMPLE_BITS-1:0] next_value
);
   import swm_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [LEN_W-1:0]              age_ff, age_in;

   logic                          src_valid;
   logic signed [SAMPLE_BITS-1:0] src_value;
   logic [LEN_W-1:0]              src_age;
   logic [LEN_W:0]                src_age_inc;
   logic                          append;

   always_comb begin
      src_valid   = ctl.shift ? right_valid : valid_ff;
      src_value   = ctl.shift ? right_value : value_ff;
      src_age     = ctl.shift ? right_age   : age_ff;
      src_age_inc = {1'b0, src_age} + {{LEN_W{1'b0}}, 1'b1};

      // survivors stay a contiguous prefix, so the new sample lands just behind them
      keep   = ctl.step & src_valid & ~ctl.restart & (src_value >= sample) &
               (src_age_inc < {1'b0, eff_len});
      append = ctl.step & ~keep & (first_cell | left_keep);

      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctl.trim) begin
         valid_in = right_valid;
         value_in = right_value;
         age_in   = right_age;
      end else if (ctl.step) begin
         valid_in = keep | append;
         value_in = append ? sample : src_value;
         age_in   = append ? '0 : src_age_inc[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid      = valid_ff;
   assign value      = value_ff;
   assign age        = age_ff;
   assign next_value = value_in;

endmodule
